// ----- hw/rtl/lcs_pkg.sv -----
package lcs_pkg;

  // Pixel and scale constants
  localparam int unsigned PIX_W      = 8;
  localparam logic [7:0]  MIN_INIT   = 8'hFF;
  localparam logic [7:0]  MAX_INIT   = 8'h00;

  // Divider: 8 quotient bits, 4 bits resolved per cycle
  localparam int unsigned DIV_BITS_PER_CYCLE = 4;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_READ = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_SEND = 5'b10000
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // input beat accepted
    logic prep;        // store read data valid, set up numerator
    logic div_step;    // step the divider
    logic advance;     // output beat accepted
    logic frame_done;  // final output beat accepted
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;    // this divider cycle is the final one
    logic emit_last;   // current output is the final pixel of the frame
  } sts_t;

endpackage

// ----- hw/rtl/linear_contrast_stretch.sv -----
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------
// in_      | input     | in_valid / in_stall  | in_pixel_in[7:0], in_frame_end
// out_     | output    | out_valid / out_stall| out_pixel_out[7:0], out_last_out,
//          |           |                      |   out_overflow_flag
//
// Loading accepts one pixel per cycle; the frame end beat switches to emission.
// For each pixel, emission steps through a store read, a numerator setup, the
// 4-bit-per-cycle divider and an output beat, which an output stall holds.
// in_stall stays high for the whole emission of a frame.
// Reset (rst_n, synchronous) empties the frame; the store itself is not cleared.
module linear_contrast_stretch import lcs_pkg::*;
  #(
    parameter int unsigned MAX_PIXELS = 64
  )
  (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [PIX_W-1:0] in_pixel_in,
    input  logic             in_frame_end,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] out_pixel_out,
    output logic             out_last_out,
    output logic             out_overflow_flag
  );

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  lcs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_frame_end (in_frame_end),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd),
    .in_stall     (in_stall),
    .out_valid    (out_valid)
  );

  // Store, statistics and divider
  lcs_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_pixel_in       (in_pixel_in),
    .sts               (sts),
    .out_pixel_out     (out_pixel_out),
    .out_last_out      (out_last_out),
    .out_overflow_flag (out_overflow_flag)
  );

endmodule

// ----- hw/rtl/lcs_ram.sv -----
module lcs_ram
  #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
  )
  (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/lcs_ctrl.sv -----
module lcs_ctrl import lcs_pkg::*;
  (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_frame_end,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd,
    output logic in_stall,
    output logic out_valid
  );

  state_t state_r;
  state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid && in_frame_end) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_PREP;
      S_PREP: state_nxt = S_DIV;
      S_DIV: begin
        if (sts.div_last) begin
          state_nxt = S_SEND;
        end
      end
      S_SEND: begin
        if (!out_stall) begin
          state_nxt = sts.emit_last ? S_LOAD : S_READ;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Handshake and commands
  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = (state_r == S_SEND);

  always_comb begin
    cmd.load       = (state_r == S_LOAD) && in_valid;
    cmd.prep       = (state_r == S_PREP);
    cmd.div_step   = (state_r == S_DIV);
    cmd.advance    = (state_r == S_SEND) && !out_stall;
    cmd.frame_done = (state_r == S_SEND) && !out_stall && sts.emit_last;
  end

  // A stalled result stays on offer
  a_send_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEND && out_stall) |=> (state_r == S_SEND))
    else $error("result dropped while stalled");

  // A frame end beat starts emission
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && in_valid && in_frame_end) |=> (state_r == S_READ))
    else $error("frame end did not start emission");

  // State register stays one-hot
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

endmodule

// ----- hw/rtl/lcs_dp.sv -----
module lcs_dp import lcs_pkg::*;
  #(
    parameter int unsigned MAX_PIXELS = 64
  )
  (
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic [PIX_W-1:0] in_pixel_in,
    output sts_t             sts,
    output logic [PIX_W-1:0] out_pixel_out,
    output logic             out_last_out,
    output logic             out_overflow_flag
  );

  localparam int unsigned AW    = $clog2(MAX_PIXELS);
  localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [PIX_W-1:0] min_r, min_nxt;
  logic [PIX_W-1:0] max_r, max_nxt;
  logic             dropped_r, dropped_nxt;
  logic [PIX_W-1:0] rem_r, rem_nxt;
  logic [PIX_W-1:0] quo_r, quo_nxt;
  logic             step_r, step_nxt;

  logic             store_we;
  logic [PIX_W-1:0] rd_data;
  logic [PIX_W-1:0] span;
  logic [PIX_W-1:0] diff;
  logic [15:0]      num;
  logic [PIX_W-1:0] rem_step;
  logic [PIX_W-1:0] quo_step;

  assign store_we = cmd.load && (count_r < CNT_W'(MAX_PIXELS));
  assign span     = max_r - min_r;

  // Frame store
  lcs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_pixel_in),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  // Numerator: (p - min) * 255 as (d << 8) - d
  assign diff = rd_data - min_r;
  assign num  = {diff, 8'h00} - {8'h00, diff};

  // Four restoring division steps per cycle
  always_comb begin
    logic [PIX_W:0]   r9;
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] q;
    r = rem_r;
    q = quo_r;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      r9 = {r, q[PIX_W-1]};
      q  = {q[PIX_W-2:0], 1'b0};
      if (r9 >= {1'b0, span}) begin
        r9   = r9 - {1'b0, span};
        q[0] = 1'b1;
      end
      r = r9[PIX_W-1:0];
    end
    rem_step = r;
    quo_step = q;
  end

  // Frame statistics and emission pointer
  always_comb begin
    count_nxt   = count_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    dropped_nxt = dropped_r;
    idx_nxt     = idx_r;
    if (cmd.load) begin
      if (store_we) begin
        count_nxt = count_r + CNT_W'(1);
        if (in_pixel_in > max_r) begin
          max_nxt = in_pixel_in;
        end
        if (in_pixel_in < min_r) begin
          min_nxt = in_pixel_in;
        end
      end else begin
        dropped_nxt = 1'b1;
      end
    end
    if (cmd.advance) begin
      idx_nxt = idx_r + AW'(1);
    end
    if (cmd.frame_done) begin
      count_nxt   = '0;
      min_nxt     = MIN_INIT;
      max_nxt     = MAX_INIT;
      dropped_nxt = 1'b0;
      idx_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      min_r     <= MIN_INIT;
      max_r     <= MAX_INIT;
      dropped_r <= 1'b0;
      idx_r     <= '0;
      step_r    <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      dropped_r <= dropped_nxt;
      idx_r     <= idx_nxt;
      step_r    <= step_nxt;
    end
  end

  // Divider registers
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    if (cmd.prep) begin
      rem_nxt  = num[15:8];
      quo_nxt  = num[7:0];
      step_nxt = 1'b0;
    end else if (cmd.div_step) begin
      rem_nxt  = rem_step;
      quo_nxt  = quo_step;
      step_nxt = ~step_r;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  // Status and result fields
  assign sts.div_last  = step_r;
  assign sts.emit_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  assign out_pixel_out     = (span == '0) ? '0 : quo_r;
  assign out_last_out      = sts.emit_last;
  assign out_overflow_flag = dropped_r;

  // Fill count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PIXELS))
    else $error("pixel count beyond capacity");

  // Emission reads only stored entries
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> (CNT_W'(idx_r) < count_r))
    else $error("emission past stored pixels");

  // A beat into a full store marks the frame
  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && count_r == CNT_W'(MAX_PIXELS)) |=> dropped_r)
    else $error("dropped pixel not flagged");

endmodule
